// File: rtl/sifs_pkg.sv
package sifs_pkg;

  // Fixed frame layout.
  localparam logic [7:0] SYNC0     = 8'hA5;
  localparam logic [7:0] SYNC1     = 8'h5A;
  localparam logic [7:0] TYPE_SCAN = 8'h01;
  localparam logic [7:0] TYPE_IMU  = 8'h02;
  localparam logic [7:0] FLAG_BASE = 8'h01;

  localparam int HDR_BYTES    = 16;
  localparam int SAMPLE_BYTES = 5;
  localparam int IMU_PAYLOAD  = 10;
  localparam int IMU_LENGTH   = HDR_BYTES + IMU_PAYLOAD + 1;

  // Largest burst one item can cause is a whole IMU frame.
  localparam int BURST_BYTES = IMU_LENGTH;
  localparam int BURST_BITS  = BURST_BYTES * 8;
  localparam int CNT_W       = $clog2(BURST_BYTES + 1);

  localparam int COUNT_W     = 12;
  localparam int FRAME_LEN_W = 14;
  localparam int NEED_W      = 15;

  localparam int unsigned MAX_SAMPLES_DEF = 2048;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_RESET = 14'd10257;

  localparam logic [1:0] KIND_SCAN_HDR = 2'd0;
  localparam logic [1:0] KIND_SAMPLE   = 2'd1;
  localparam logic [1:0] KIND_IMU      = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        sequence_req;
    logic [31:0]        time_ms;
    logic [COUNT_W-1:0] sample_count;
    logic               truncated;
    logic [15:0]        sample_angle;
    logic [15:0]        sample_distance;
    logic [7:0]         sample_quality;
    logic signed [15:0] yaw;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             byte_value;
    logic                   frame_end;
    logic [FRAME_LEN_W-1:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0]             running_xor;
    logic [COUNT_W-1:0]     samples_left;
    logic                   scan_open;
    logic                   scan_dropping;
    logic [FRAME_LEN_W-1:0] current_length;
  } scan_state_t;

  // Bytes one item emits: byte i sits at bits [8*i +: 8].
  typedef struct packed {
    logic [BURST_BITS-1:0]  bytes;
    logic [CNT_W-1:0]       count;
    logic                   has_end;
    logic [FRAME_LEN_W-1:0] length;
  } burst_t;

  // The 16 header bytes, little-endian fields, sync byte first.
  function automatic logic [HDR_BYTES*8-1:0] hdr_bytes(
    input logic [7:0]  ftype,
    input logic [7:0]  flags,
    input logic [31:0] seq,
    input logic [31:0] t,
    input logic [15:0] cnt,
    input logic [15:0] plen
  );
    hdr_bytes = {plen, cnt, t, seq, flags, ftype, SYNC1, SYNC0};
  endfunction

  function automatic logic [7:0] xor_bytes(input logic [BURST_BITS-1:0] v);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < BURST_BYTES; i++) begin
      acc = acc ^ v[8*i +: 8];
    end
    xor_bytes = acc;
  endfunction

endpackage

// File: rtl/sifs_stream_if.sv
interface sifs_in_if import sifs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sifs_out_if import sifs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sifs_frame_build.sv
// Works out, for one item, the bytes it emits and the scan state it leaves.
module sifs_frame_build import sifs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  in_item_t               item,
  input  scan_state_t            st,
  input  logic [FRAME_LEN_W-1:0] max_frame_bytes,
  output scan_state_t            st_nxt,
  output burst_t                 burst
);

  logic [NEED_W-1:0]      need;
  logic [15:0]            plen;
  logic                   too_many;
  logic                   too_long;
  logic [7:0]             flags;
  logic [7:0]             chk;
  logic [COUNT_W-1:0]     left_dec;
  logic [BURST_BITS-1:0]  vec;

  always_comb begin
    need     = (NEED_W'(item.sample_count) << 2) + NEED_W'(item.sample_count)
               + NEED_W'(HDR_BYTES + 1);
    plen     = (16'(item.sample_count) << 2) + 16'(item.sample_count);
    too_many = 32'(item.sample_count) > 32'(MAX_SAMPLES);
    too_long = need > {1'b0, max_frame_bytes};
    flags    = FLAG_BASE | {6'd0, item.truncated, 1'b0};
    left_dec = st.samples_left - COUNT_W'(1);
    vec      = '0;
    chk      = 8'h00;
    st_nxt   = st;
    burst    = '0;

    unique case (item.kind)
      KIND_SCAN_HDR: begin
        st_nxt = '0;
        if (too_many || too_long) begin
          if (item.sample_count != '0) begin
            st_nxt.scan_open     = 1'b1;
            st_nxt.scan_dropping = 1'b1;
            st_nxt.samples_left  = item.sample_count;
          end
        end else begin
          vec = BURST_BITS'(hdr_bytes(TYPE_SCAN, flags, item.sequence_req, item.time_ms,
                                      16'(item.sample_count), plen));
          chk = xor_bytes(vec);
          burst.length = need[FRAME_LEN_W-1:0];
          if (item.sample_count == '0) begin
            vec[8*HDR_BYTES +: 8] = chk;
            burst.count   = CNT_W'(HDR_BYTES + 1);
            burst.has_end = 1'b1;
          end else begin
            burst.count           = CNT_W'(HDR_BYTES);
            st_nxt.scan_open      = 1'b1;
            st_nxt.samples_left   = item.sample_count;
            st_nxt.running_xor    = chk;
            st_nxt.current_length = need[FRAME_LEN_W-1:0];
          end
          burst.bytes = vec;
        end
      end
      KIND_SAMPLE: begin
        if (st.scan_open) begin
          st_nxt.samples_left = left_dec;
          if (st.scan_dropping) begin
            if (left_dec == '0) begin
              st_nxt.scan_open     = 1'b0;
              st_nxt.scan_dropping = 1'b0;
            end
          end else begin
            vec = BURST_BITS'({item.sample_quality, item.sample_distance,
                               item.sample_angle});
            chk = st.running_xor ^ xor_bytes(vec);
            burst.length = st.current_length;
            if (left_dec == '0) begin
              vec[8*SAMPLE_BYTES +: 8] = chk;
              burst.count           = CNT_W'(SAMPLE_BYTES + 1);
              burst.has_end         = 1'b1;
              st_nxt.scan_open      = 1'b0;
              st_nxt.running_xor    = 8'h00;
              st_nxt.current_length = '0;
            end else begin
              burst.count        = CNT_W'(SAMPLE_BYTES);
              st_nxt.running_xor = chk;
            end
            burst.bytes = vec;
          end
        end
      end
      KIND_IMU: begin
        if ({1'b0, max_frame_bytes} >= NEED_W'(IMU_LENGTH)) begin
          vec = BURST_BITS'({16'h0000, item.accel_z, item.accel_y, item.accel_x, item.yaw,
                             hdr_bytes(TYPE_IMU, FLAG_BASE, item.sequence_req,
                                       item.time_ms, 16'd1, 16'(IMU_PAYLOAD))});
          chk = xor_bytes(vec);
          vec[8*(IMU_LENGTH-1) +: 8] = chk;
          burst.bytes   = vec;
          burst.count   = CNT_W'(IMU_LENGTH);
          burst.has_end = 1'b1;
          burst.length  = FRAME_LEN_W'(IMU_LENGTH);
        end
      end
      default: begin
        // The unused kind code emits nothing and leaves the state alone.
      end
    endcase
  end

endmodule

// File: rtl/scan_and_imu_frame_serializer.sv
// Channel   Direction  Contents
// in_ch     sink       one item: scan header, scan sample or IMU record
// out_ch    source     one item per frame byte: byte, end-of-frame mark, frame length
// cfg_*     write      max_frame_bytes, written whenever cfg_wr_en is high
//
// Bytes leave the output register at one per cycle while out_ch is ready. A scan
// header emits 16 bytes (17 for an empty scan), a sample 5 (6 with the checksum),
// an IMU record 27, each byte by way of the burst register. An item that emits
// nothing does not load the burst register. The next item is accepted in the
// cycle the last byte of the current burst moves to the output register.
// Reset is synchronous: scan state, both valid flags and the capacity register
// return to their reset values. A stall on out_ch holds the output item and,
// once the burst register is full, holds in_ch too.
module scan_and_imu_frame_serializer import sifs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [FRAME_LEN_W-1:0] cfg_wr_data,
  sifs_in_if.sink                in_ch,
  sifs_out_if.source             out_ch
);

  // Capacity register and scan state carried from item to item.
  logic [FRAME_LEN_W-1:0] max_frame_r;
  scan_state_t            st_r;
  scan_state_t            st_nxt;
  burst_t                 burst;

  // Burst register: the bytes of the item being sent, shifted down one byte
  // each time a byte moves to the output register.
  logic [BURST_BITS-1:0]  buf_bytes_r;
  logic [CNT_W-1:0]       buf_cnt_r;
  logic [CNT_W-1:0]       buf_idx_r;
  logic                   buf_end_r;
  logic [FRAME_LEN_W-1:0] buf_len_r;
  logic                   buf_valid_r;

  // Output register.
  out_item_t              out_r;
  logic                   out_valid_r;

  logic move;
  logic last;
  logic in_ready;
  logic in_fire;

  sifs_frame_build #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_build (
    .item            (in_ch.data),
    .st              (st_r),
    .max_frame_bytes (max_frame_r),
    .st_nxt          (st_nxt),
    .burst           (burst)
  );

  // A byte moves whenever the output register is empty or being emptied.
  assign move     = buf_valid_r && (!out_valid_r || out_ch.ready);
  assign last     = buf_idx_r == (buf_cnt_r - CNT_W'(1));
  assign in_ready = !buf_valid_r || (move && last);
  assign in_fire  = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_frame_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      buf_idx_r   <= '0;
    end else begin
      if (in_fire && (burst.count != '0)) begin
        buf_valid_r <= 1'b1;
        buf_idx_r   <= '0;
      end else if (move) begin
        buf_valid_r <= !last;
        buf_idx_r   <= buf_idx_r + CNT_W'(1);
      end
    end
  end

  // Burst payload needs no reset; buf_valid_r qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire && (burst.count != '0)) begin
      buf_bytes_r <= burst.bytes;
      buf_cnt_r   <= burst.count;
      buf_end_r   <= burst.has_end;
      buf_len_r   <= burst.length;
    end else if (move) begin
      buf_bytes_r <= buf_bytes_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r.byte_value   <= buf_bytes_r[7:0];
      out_r.frame_end    <= buf_end_r && last;
      out_r.frame_length <= buf_len_r;
    end
  end

endmodule

// File: rtl/sifs_checker.sv
module sifs_checker import sifs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A waiting output item stays offered.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item withdrawn while stalled");

  // A waiting output item keeps its payload.
  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Holding off the input means bytes are pending, so output follows.
  a_busy_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("input held off with no output byte offered");

  // A byte offered alongside an input item carries a legal frame length.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_valid |-> out_data.frame_length >= FRAME_LEN_W'(HDR_BYTES + 1))
    else $error("output frame length below a header and checksum");

endmodule

bind scan_and_imu_frame_serializer sifs_checker u_sifs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: dv/sifs_frame_check.sv
// Watches both channels of the frame serializer, predicts the byte stream
// and compares every byte that leaves the block with the oldest prediction.
module sifs_frame_check import sifs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [FRAME_LEN_W-1:0] cfg_wr_data,
  sifs_in_if                     in_ch,
  sifs_out_if                    out_ch,
  output int                     fail_count,
  output int                     bytes_pending
);

  // Predicted serializer state.
  logic [FRAME_LEN_W-1:0] capacity;
  logic [7:0]             scan_xor;
  logic [COUNT_W-1:0]     scan_samples_left;
  logic                   scan_active;
  logic                   scan_discarding;
  logic [FRAME_LEN_W-1:0] scan_frame_len;

  out_item_t frame_bytes_due[$];

  function automatic void emit(input logic [7:0] b, input logic fend,
                               input logic [FRAME_LEN_W-1:0] len,
                               inout logic [7:0] x);
    out_item_t o;
    o.byte_value   = b;
    o.frame_end    = fend;
    o.frame_length = len;
    frame_bytes_due.push_back(o);
    x = x ^ b;
  endfunction

  function automatic void emit_le(input logic [31:0] v, input int nbytes,
                                  input logic [FRAME_LEN_W-1:0] len,
                                  inout logic [7:0] x);
    for (int i = 0; i < nbytes; i++) begin
      emit(v[8*i +: 8], 1'b0, len, x);
    end
  endfunction

  function automatic void emit_header(input logic [7:0] ftype, input logic [7:0] flags,
                                      input logic [31:0] seq, input logic [31:0] t,
                                      input logic [15:0] cnt, input logic [15:0] plen,
                                      input logic [FRAME_LEN_W-1:0] len,
                                      inout logic [7:0] x);
    emit(SYNC0, 1'b0, len, x);
    emit(SYNC1, 1'b0, len, x);
    emit(ftype, 1'b0, len, x);
    emit(flags, 1'b0, len, x);
    emit_le(seq, 4, len, x);
    emit_le(t, 4, len, x);
    emit_le(32'(cnt), 2, len, x);
    emit_le(32'(plen), 2, len, x);
  endfunction

  // Works out the bytes one accepted item causes and advances the scan state.
  function automatic void serialize_item(input in_item_t it);
    logic [7:0]             x;
    int                     n;
    int                     need;
    logic [FRAME_LEN_W-1:0] len;
    x    = 8'h00;
    n    = int'(it.sample_count);
    need = HDR_BYTES + SAMPLE_BYTES * n + 1;
    len  = FRAME_LEN_W'(need);
    case (it.kind)
      KIND_SCAN_HDR: begin
        // A new header always abandons whatever scan was in progress.
        scan_active       = 1'b0;
        scan_discarding   = 1'b0;
        scan_samples_left = '0;
        scan_xor          = 8'h00;
        scan_frame_len    = '0;
        if (n > int'(MAX_SAMPLES) || need > int'(capacity)) begin
          if (n != 0) begin
            scan_active       = 1'b1;
            scan_discarding   = 1'b1;
            scan_samples_left = it.sample_count;
          end
        end else begin
          emit_header(TYPE_SCAN, FLAG_BASE | {6'd0, it.truncated, 1'b0},
                      it.sequence_req, it.time_ms, 16'(n), 16'(SAMPLE_BYTES * n), len, x);
          if (n == 0) begin
            emit(x, 1'b1, len, x);
          end else begin
            scan_active       = 1'b1;
            scan_samples_left = it.sample_count;
            scan_xor          = x;
            scan_frame_len    = len;
          end
        end
      end
      KIND_SAMPLE: begin
        if (scan_active) begin
          scan_samples_left = scan_samples_left - 1'b1;
          if (scan_discarding) begin
            if (scan_samples_left == '0) begin
              scan_active     = 1'b0;
              scan_discarding = 1'b0;
            end
          end else begin
            x = scan_xor;
            emit_le(32'(it.sample_angle), 2, scan_frame_len, x);
            emit_le(32'(it.sample_distance), 2, scan_frame_len, x);
            emit(it.sample_quality, 1'b0, scan_frame_len, x);
            if (scan_samples_left == '0) begin
              emit(x, 1'b1, scan_frame_len, x);
              scan_active    = 1'b0;
              x              = 8'h00;
              scan_frame_len = '0;
            end
            scan_xor = x;
          end
        end
      end
      KIND_IMU: begin
        if (IMU_LENGTH <= int'(capacity)) begin
          len = FRAME_LEN_W'(IMU_LENGTH);
          emit_header(TYPE_IMU, FLAG_BASE, it.sequence_req, it.time_ms, 16'd1,
                      16'(IMU_PAYLOAD), len, x);
          emit_le(32'(16'(it.yaw)), 2, len, x);
          emit_le(32'(16'(it.accel_x)), 2, len, x);
          emit_le(32'(16'(it.accel_y)), 2, len, x);
          emit_le(32'(16'(it.accel_z)), 2, len, x);
          emit_le(32'd0, 2, len, x);
          emit(x, 1'b1, len, x);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Outgoing bytes are checked before the incoming item of the same edge is
  // predicted, so a byte cannot be matched against its own item's bytes.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      capacity          = MAX_FRAME_RESET;
      scan_xor          = 8'h00;
      scan_samples_left = '0;
      scan_active       = 1'b0;
      scan_discarding   = 1'b0;
      scan_frame_len    = '0;
      frame_bytes_due.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (frame_bytes_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: unexpected byte %h end %b length %0d",
                     out_ch.data.byte_value, out_ch.data.frame_end,
                     out_ch.data.frame_length);
          end
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_ch.data.byte_value !== want.byte_value ||
              out_ch.data.frame_end !== want.frame_end ||
              out_ch.data.frame_length !== want.frame_length) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: byte %h/%h end %b/%b length %0d/%0d (expected/actual)",
                       want.byte_value, out_ch.data.byte_value,
                       want.frame_end, out_ch.data.frame_end,
                       want.frame_length, out_ch.data.frame_length);
            end
          end
        end
      end
      if (cfg_wr_en === 1'b1) begin
        capacity = cfg_wr_data;
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        serialize_item(in_ch.data);
      end
    end
    bytes_pending = frame_bytes_due.size();
  end

endmodule

// File: dv/scan_and_imu_frame_serializer_tb.sv
// Top of the serializer testbench. It drives the item stream, the receiver's
// ready and the capacity register; all prediction and comparison is done by
// the frame check module beside the block, which reports a failure count.
module scan_and_imu_frame_serializer_tb;
  import sifs_pkg::*;

  localparam int unsigned SAMPLE_LIMIT = MAX_SAMPLES_DEF;
  // Kind code with no meaning to the block; it must be ignored.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles allowed after the stream drains, covering an item that emits
  // nothing and is still being absorbed by the block.
  localparam int SETTLE_CYCLES = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [FRAME_LEN_W-1:0] cfg_wr_data;
  int                     fail_count;
  int                     bytes_pending;
  int                     sender_calm;
  int                     receiver_calm;

  sifs_in_if  in_ch ();
  sifs_out_if out_ch ();

  scan_and_imu_frame_serializer #(
    .MAX_SAMPLES(SAMPLE_LIMIT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  sifs_frame_check #(
    .MAX_SAMPLES(SAMPLE_LIMIT)
  ) stream_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .bytes_pending(bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or holds back bytes. The slowest
  // correct run is far below this: a few hundred items at up to 27 bytes,
  // each byte waiting out the longest receiver stall.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Random idle gap before the next item or result, with occasional
  // stretches where the side does not idle at all.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Every field gets random content; callers override what matters.
  function automatic in_item_t random_item(input logic [1:0] kind);
    in_item_t it;
    it.kind            = kind;
    it.sequence_req    = $urandom;
    it.time_ms         = $urandom;
    it.sample_count    = COUNT_W'($urandom_range(0, 4095));
    it.truncated       = 1'($urandom_range(0, 1));
    it.sample_angle    = 16'($urandom);
    it.sample_distance = 16'($urandom);
    it.sample_quality  = 8'($urandom);
    it.yaw             = 16'($urandom);
    it.accel_x         = 16'($urandom);
    it.accel_y         = 16'($urandom);
    it.accel_z         = 16'($urandom);
    return it;
  endfunction

  function automatic in_item_t scan_header(input int count, input logic trunc);
    in_item_t it;
    it              = random_item(KIND_SCAN_HDR);
    it.sample_count = COUNT_W'(count);
    it.truncated    = trunc;
    return it;
  endfunction

  // Offers one item and returns at the edge where it is accepted. Valid is
  // left high so that a back-to-back item is offered without a gap.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
  endtask

  // Holds the sender until every predicted byte has left the block. The
  // first edge lets the check module take in the last accepted item.
  task automatic wait_for_stream_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The capacity register is only written while the block is idle.
  task automatic set_capacity(input int value);
    wait_for_stream_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= FRAME_LEN_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed scans with random content, mixed with IMU records,
  // stray samples, unused kinds, abandoned and oversized scans, and pauses.
  task automatic run_random_traffic(input int goal);
    int done_items;
    int pick;
    int cnt;
    int r;
    done_items = 0;
    while (done_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        send_item(scan_header(cnt, 1'($urandom_range(0, 1))));
        done_items++;
        for (int i = 0; i < cnt; i++) begin
          r = $urandom_range(0, 39);
          // An IMU record may cut into a scan without disturbing it.
          if (r == 0) begin
            send_item(random_item(KIND_IMU));
            done_items++;
          end
          // Leave the scan unfinished; a later header abandons it.
          if (r == 1) break;
          send_item(random_item(KIND_SAMPLE));
          done_items++;
        end
      end else if (pick < 80) begin
        send_item(random_item(KIND_IMU));
        done_items++;
      end else if (pick < 86) begin
        send_item(random_item(KIND_SAMPLE));
      end else if (pick < 90) begin
        send_item(random_item(KIND_UNUSED));
      end else if (pick < 96) begin
        // Header with any count the field allows: large ones are dropped
        // and their samples swallowed; a few samples follow.
        send_item(random_item(KIND_SCAN_HDR));
        done_items++;
        r = $urandom_range(0, 3);
        repeat (r) send_item(random_item(KIND_SAMPLE));
      end else begin
        wait_for_stream_drain();
      end
    end
  endtask

  // The receiver stalls before each byte for a drawn number of cycles.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(receiver_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  initial begin
    in_item_t it;
    sender_calm   = 0;
    receiver_calm = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity. IMU records with the extreme
    // signed values and the extreme sequence and time words.
    it = random_item(KIND_IMU);
    it.sequence_req = '0;
    it.time_ms      = '1;
    it.yaw          = 16'sh8000;
    it.accel_x      = 16'sh7FFF;
    it.accel_y      = -16'sd1;
    it.accel_z      = 16'sd0;
    send_item(it);
    it = random_item(KIND_IMU);
    it.sequence_req = '1;
    it.time_ms      = '0;
    it.yaw          = 16'sh7FFF;
    it.accel_x      = 16'sh8000;
    it.accel_y      = 16'sd0;
    it.accel_z      = -16'sd1;
    send_item(it);

    // An empty scan closes at once; then a stray sample and an unused kind.
    send_item(scan_header(0, 1'b1));
    send_item(random_item(KIND_SAMPLE));
    send_item(random_item(KIND_UNUSED));

    // A two-sample scan with an IMU record in the middle of it.
    send_item(scan_header(2, 1'b0));
    it = random_item(KIND_SAMPLE);
    it.sample_angle    = '1;
    it.sample_distance = '0;
    it.sample_quality  = '1;
    send_item(it);
    send_item(random_item(KIND_IMU));
    it = random_item(KIND_SAMPLE);
    it.sample_angle    = '0;
    it.sample_distance = '1;
    it.sample_quality  = '0;
    send_item(it);

    // The largest allowed scan fills the capacity exactly; it is abandoned
    // by a header with too many samples, whose own scan is swallowed until
    // yet another header takes over.
    send_item(scan_header(SAMPLE_LIMIT, 1'b1));
    send_item(random_item(KIND_SAMPLE));
    send_item(scan_header(4095, 1'b0));
    send_item(random_item(KIND_SAMPLE));
    send_item(scan_header(SAMPLE_LIMIT + 1, 1'b1));
    send_item(scan_header(1, 1'b0));
    send_item(random_item(KIND_SAMPLE));

    // Smallest capacity: only an empty scan fits; IMU and a one-sample scan
    // are dropped, and the dropped scan's sample is consumed silently.
    set_capacity(17);
    send_item(scan_header(0, 1'b0));
    send_item(random_item(KIND_IMU));
    send_item(scan_header(1, 1'b1));
    send_item(random_item(KIND_SAMPLE));
    send_item(random_item(KIND_SAMPLE));

    // Capacity that just fits an IMU frame and a two-sample scan.
    set_capacity(IMU_LENGTH);
    send_item(random_item(KIND_IMU));
    send_item(scan_header(2, 1'b1));
    repeat (2) send_item(random_item(KIND_SAMPLE));
    send_item(scan_header(3, 1'b0));
    repeat (4) send_item(random_item(KIND_SAMPLE));

    // Random part over several capacity settings.
    set_capacity($urandom_range(28, 120));
    run_random_traffic(35);
    set_capacity(int'(MAX_FRAME_RESET));
    run_random_traffic(35);
    set_capacity($urandom_range(17, 10257));
    run_random_traffic(35);

    // Drain, allow the block to settle, then give the verdict.
    wait_for_stream_drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
